>>> sv/task_delay_tick_table_defines.svh
// ----------------------------------------------------------------------------
// Task delay tick table assertion macros
// Shared assertion forms for the tick table RTL.
// ----------------------------------------------------------------------------
`ifndef TASK_DELAY_TICK_TABLE_DEFINES_SVH
`define TASK_DELAY_TICK_TABLE_DEFINES_SVH

// check on every clock edge once reset has been released
`define TDTT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define TDTT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/tdtt_pkg.sv
// ----------------------------------------------------------------------------
// Task delay tick table package
// Request and result types, operation codes and the stored slot word.
// ----------------------------------------------------------------------------
package tdtt_pkg;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_WRITE   = 2'd1,
		OP_CONSUME = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  slot;
		logic        present;
		logic [15:0] first_delay;
		logic [15:0] repeat_period;
	} req_t;

	typedef struct packed {
		logic [7:0] due_mask;
		logic [7:0] pending_runs;
	} rsp_t;

	typedef struct packed {
		logic [15:0] delay;
		logic [15:0] period;
		logic [7:0]  runs;
	} slot_t;

	localparam int unsigned SLOT_W   = $bits(slot_t);
	localparam int unsigned MASK_W   = 8;
	localparam logic [7:0]  RUNS_MAX = 8'hFF;

endpackage

>>> sv/tdtt_ram.sv
// ----------------------------------------------------------------------------
// Task delay tick table RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module tdtt_ram #(
	parameter int unsigned WIDTH = 40,
	parameter int unsigned DEPTH = 8,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> sv/task_delay_tick_table.sv
// ----------------------------------------------------------------------------
// Task delay tick table
// Tick: walks the slots in order, one slot per cycle through the slot RAM
// read port and the shared update unit. One request at a time.
// Write: RAM write, then ST_RESP. Consume: read, ST_CONS, then ST_RESP.
// Reset clears present and written flags at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "task_delay_tick_table_defines.svh"

module task_delay_tick_table #(
	parameter int unsigned MAX_TASKS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  tdtt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tdtt_pkg::rsp_t rsp
);

	import tdtt_pkg::*;

	localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_CONS,
		ST_RESP
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [MAX_TASKS-1:0] present_q;
	logic [MAX_TASKS-1:0] written_q;
	rsp_t                 res_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic                 accept;
	logic                 in_range;
	logic [IDX_W-1:0]     req_addr;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	slot_t                wr_data;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic [SLOT_W-1:0]    rd_data;
	slot_t                cur;
	slot_t                upd;
	logic                 upd_due;

	tdtt_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (MAX_TASKS),
		.AW    (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// shared update unit: tick step or consume step on the slot just read
	always_comb begin
		cur     = written_q[idx_q] ? slot_t'(rd_data) : '0;
		upd     = cur;
		upd_due = 1'b0;
		if (state_q == ST_CONS) begin
			if (cur.runs != 8'd0) begin
				upd.runs = cur.runs - 8'd1;
			end
		end else begin
			if (cur.delay == 16'd0) begin
				upd_due = 1'b1;
				if (cur.runs != RUNS_MAX) begin
					upd.runs = cur.runs + 8'd1;
				end
				if (cur.period != 16'd0) begin
					upd.delay = cur.period;
				end
			end else begin
				upd.delay = cur.delay - 16'd1;
			end
		end
	end

	always_comb begin
		req_stall = (state_q != ST_IDLE);
		accept    = req_valid && !req_stall;
		in_range  = (32'(req.slot) < MAX_TASKS);
		req_addr  = IDX_W'(req.slot);
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = upd;
		rd_en     = 1'b0;
		rd_addr   = idx_q + 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.op)
						OP_TICK: begin
							rd_en   = 1'b1;
							rd_addr = '0;
						end
						OP_WRITE: begin
							wr_en   = in_range;
							wr_addr = req_addr;
							wr_data = req.present ?
								slot_t'({req.first_delay, req.repeat_period, 8'd0}) : '0;
						end
						OP_CONSUME: begin
							rd_en   = in_range;
							rd_addr = req_addr;
						end
						default: begin
						end
					endcase
				end
			end
			ST_TICK: begin
				wr_en = present_q[idx_q];
				rd_en = (idx_q != LAST_IDX);
			end
			ST_CONS: begin
				wr_en = 1'b1;
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			present_q   <= '0;
			written_q   <= '0;
			idx_q       <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != ST_RESP)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q <= '0;
						unique case (req.op)
							OP_TICK: begin
								idx_q   <= '0;
								state_q <= ST_TICK;
							end
							OP_WRITE: begin
								if (in_range) begin
									present_q[req_addr] <= req.present;
									written_q[req_addr] <= 1'b1;
								end
								state_q <= ST_RESP;
							end
							OP_CONSUME: begin
								idx_q   <= req_addr;
								state_q <= in_range ? ST_CONS : ST_RESP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_TICK: begin
					if (present_q[idx_q] && upd_due && (32'(idx_q) < MASK_W)) begin
						res_q.due_mask[3'(idx_q)] <= 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= ST_RESP;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CONS: begin
					res_q.pending_runs <= cur.runs;
					state_q            <= ST_RESP;
				end
				ST_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`TDTT_ASSERT(a_tick_walk_ends, (state_q == ST_TICK && idx_q == LAST_IDX) |=> (state_q == ST_RESP), "tick walk did not end at the last slot")
	`TDTT_ASSERT(a_no_write_in_resp, wr_en |-> (state_q != ST_RESP), "slot RAM written while holding a result")
	`TDTT_ASSERT(a_present_written, (present_q & ~written_q) == '0, "present slot never written")
	`TDTT_ASSERT(a_request_taken, (req_valid && !req_stall) |=> (state_q != ST_IDLE), "accepted request dropped")

endmodule
